// File: rtl/core/dtq_pkg.sv
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          RESULT_CAP = 8;
	localparam int          PADDR_W    = 3;

	localparam logic [PADDR_W-1:0] ADDR_TICK_RATE = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_HANDLER   = 3'd4;

	typedef enum logic [1:0] {
		KIND_SCHED  = 2'd0,
		KIND_CANCEL = 2'd1,
		KIND_TICK   = 2'd2,
		KIND_RSVD   = 2'd3
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [2:0]  timer_id;
		logic [63:0] first_delay;
		logic [63:0] repeat_period;
		logic [63:0] now_time;
	} cmd_t;

	typedef struct packed {
		logic        status;
		logic        fired_valid;
		logic [2:0]  fired_id;
		logic        last;
		logic [63:0] next_deadline;
	} res_t;

	// item as classified by the front end
	typedef struct packed {
		cmd_t cmd;
		logic sched_ok;
		logic id_ok;
	} q_item_t;

	typedef struct packed {
		logic    valid;
		q_item_t item;
	} q_link_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CMD,
		ST_UNLINK,
		ST_LPOS,
		ST_LINS,
		ST_SCAN,
		ST_ADV,
		ST_DIV,
		ST_HEAD,
		ST_EMIT
	} state_t;

endpackage

// File: rtl/core/dtq_div.sv
// ----------------------------------------------------------------------------
// dtq_div
// Restoring 64-bit divider, one quotient bit per cycle, remainder only.
// ----------------------------------------------------------------------------
module dtq_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] remainder
);

	logic [63:0] rem_q;
	logic [63:0] dvd_q;
	logic [63:0] dvs_q;
	logic [6:0]  cnt_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {rem_q, dvd_q[63]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[62:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= 64'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[63:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

// File: rtl/core/dtq_front.sv
// ----------------------------------------------------------------------------
// dtq_front
// Accepts commands, checks them against the config, and queues them.
// ----------------------------------------------------------------------------
module dtq_front #(
	parameter int TIMERS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  dtq_pkg::cmd_t        cmd,
	output logic                 busy,
	input  logic [31:0]          tick_rate,
	input  logic [7:0]           handler_mask,
	output dtq_pkg::q_link_t     q_out,
	input  logic                 q_pop
);

	dtq_pkg::q_item_t ent_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;
	logic             id_ok;
	dtq_pkg::q_item_t item;

	assign id_ok = int'(cmd.timer_id) < TIMERS;

	always_comb begin
		item          = '0;
		item.cmd      = cmd;
		item.id_ok    = id_ok;
		item.sched_ok = (cmd.kind == dtq_pkg::KIND_SCHED) && id_ok &&
			handler_mask[cmd.timer_id] && (tick_rate != '0);
	end

	assign busy  = (cnt_q == 2'd2);
	assign push  = start && !busy;
	assign pop   = q_pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			cnt_q <= 2'(cnt_q + {1'b0, push} - {1'b0, pop});
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= item;
		end
	end

	assign q_out.valid = (cnt_q != '0);
	assign q_out.item  = ent_q[rd_ptr_q];

endmodule

// File: rtl/core/dtq_back.sv
// ----------------------------------------------------------------------------
// dtq_back
// Executes queued commands on the slot table and emits the results.
// ----------------------------------------------------------------------------
module dtq_back #(
	parameter int TIMERS = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  dtq_pkg::q_link_t q_in,
	output logic             q_pop,
	output logic             result_valid,
	output dtq_pkg::res_t    result
);

	localparam int SW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

	dtq_pkg::state_t  state_q, state_d;
	dtq_pkg::q_item_t op_q;
	logic [SW-1:0]    tgt_q;
	logic [63:0]      new_d_q;
	logic             link_after_q;
	logic [SW-1:0]    pos_q;
	logic [63:0]      dl_q   [TIMERS];
	logic [63:0]      per_q  [TIMERS];
	logic [TIMERS-1:0] act_q;
	logic [SW-1:0]    rank_q [TIMERS];
	logic [SW-1:0]    fired_q [dtq_pkg::RESULT_CAP];
	logic [3:0]       nfired_q;
	logic [TIMERS-1:0] fmask_q;
	logic [63:0]      next_q;
	logic [2:0]       emit_q;

	logic             head_found;
	logic [SW-1:0]    head_id;
	logic             fire;
	logic [63:0]      now;
	logic [63:0]      sch_d;
	logic [64:0]      sch_sum;
	logic [64:0]      adv_sum;
	logic [63:0]      adv_d1;
	logic             need_div;
	logic [64:0]      fin_sum;
	logic [SW:0]      pos_cnt;
	logic             div_start;
	logic             div_done;
	logic [63:0]      div_rem;
	logic             is_tick;
	logic             emit_last;

	assign now     = op_q.cmd.now_time;
	assign is_tick = (op_q.cmd.kind == dtq_pkg::KIND_TICK);

	// head of the order: active slot with rank zero
	always_comb begin
		head_found = 1'b0;
		head_id    = '0;
		for (int j = 0; j < TIMERS; j++) begin
			if (act_q[j] && rank_q[j] == '0) begin
				head_found = 1'b1;
				head_id    = SW'(j);
			end
		end
	end

	assign fire = head_found && (dl_q[head_id] <= now) && !fmask_q[head_id] &&
		(nfired_q < 4'(dtq_pkg::RESULT_CAP));

	// schedule deadline: now + max(delay, 1), saturating
	always_comb begin
		sch_sum = {1'b0, now} + {1'b0, (op_q.cmd.first_delay == '0) ? 64'd1 :
			op_q.cmd.first_delay};
		sch_d   = sch_sum[64] ? dtq_pkg::ALL_ONES : sch_sum[63:0];
	end

	// periodic advance: first step, then remainder-based catch-up
	assign adv_sum  = {1'b0, dl_q[tgt_q]} + {1'b0, per_q[tgt_q]};
	assign adv_d1   = adv_sum[64] ? dtq_pkg::ALL_ONES : adv_sum[63:0];
	assign need_div = !((adv_d1 > now) || (adv_d1 == dtq_pkg::ALL_ONES));
	assign fin_sum  = {1'b0, 64'(now - div_rem)} + {1'b0, per_q[tgt_q]};
	assign div_start = (state_q == dtq_pkg::ST_ADV) && need_div;

	dtq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (64'(now - adv_d1)),
		.divisor   (per_q[tgt_q]),
		.done      (div_done),
		.remainder (div_rem)
	);

	// insertion position: active slots with deadline at or before the new one
	always_comb begin
		pos_cnt = '0;
		for (int j = 0; j < TIMERS; j++) begin
			if (act_q[j] && SW'(j) != tgt_q && dl_q[j] <= new_d_q) begin
				pos_cnt = (SW+1)'(pos_cnt + 1'b1);
			end
		end
	end

	assign emit_last = (nfired_q == '0) || ({1'b0, emit_q} == 4'(nfired_q - 4'd1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dtq_pkg::ST_IDLE: if (q_in.valid) state_d = dtq_pkg::ST_CMD;
			dtq_pkg::ST_CMD: begin
				unique case (op_q.cmd.kind)
					dtq_pkg::KIND_SCHED:
						state_d = op_q.sched_ok ? dtq_pkg::ST_UNLINK : dtq_pkg::ST_HEAD;
					dtq_pkg::KIND_CANCEL:
						state_d = op_q.id_ok ? dtq_pkg::ST_UNLINK : dtq_pkg::ST_HEAD;
					dtq_pkg::KIND_TICK:   state_d = dtq_pkg::ST_SCAN;
					dtq_pkg::KIND_RSVD:   state_d = dtq_pkg::ST_HEAD;
					default:              state_d = dtq_pkg::ST_HEAD;
				endcase
			end
			dtq_pkg::ST_UNLINK: begin
				if (link_after_q)  state_d = dtq_pkg::ST_LPOS;
				else if (is_tick)  state_d = dtq_pkg::ST_SCAN;
				else               state_d = dtq_pkg::ST_HEAD;
			end
			dtq_pkg::ST_LPOS: state_d = dtq_pkg::ST_LINS;
			dtq_pkg::ST_LINS: state_d = is_tick ? dtq_pkg::ST_SCAN : dtq_pkg::ST_HEAD;
			dtq_pkg::ST_SCAN: begin
				if (!fire)                       state_d = dtq_pkg::ST_HEAD;
				else if (per_q[head_id] != '0)   state_d = dtq_pkg::ST_ADV;
				else                             state_d = dtq_pkg::ST_UNLINK;
			end
			dtq_pkg::ST_ADV: state_d = need_div ? dtq_pkg::ST_DIV : dtq_pkg::ST_UNLINK;
			dtq_pkg::ST_DIV: if (div_done) state_d = dtq_pkg::ST_UNLINK;
			dtq_pkg::ST_HEAD: state_d = dtq_pkg::ST_EMIT;
			dtq_pkg::ST_EMIT: if (emit_last) state_d = dtq_pkg::ST_IDLE;
			default: state_d = dtq_pkg::ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		q_pop               = (state_q == dtq_pkg::ST_IDLE) && q_in.valid;
		result_valid        = (state_q == dtq_pkg::ST_EMIT);
		result.status       = (op_q.cmd.kind == dtq_pkg::KIND_SCHED) && !op_q.sched_ok;
		result.fired_valid  = (nfired_q != '0);
		result.fired_id     = (nfired_q != '0) ? 3'(int'(fired_q[emit_q])) : 3'd0;
		result.last         = emit_last;
		result.next_deadline = next_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= dtq_pkg::ST_IDLE;
			act_q    <= '0;
			nfired_q <= '0;
			fmask_q  <= '0;
			emit_q   <= '0;
			for (int j = 0; j < TIMERS; j++) rank_q[j] <= '0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				dtq_pkg::ST_CMD: begin
					nfired_q <= '0;
					fmask_q  <= '0;
					emit_q   <= '0;
				end
				dtq_pkg::ST_UNLINK: begin
					if (act_q[tgt_q]) begin
						for (int j = 0; j < TIMERS; j++) begin
							if (act_q[j] && rank_q[j] > rank_q[tgt_q]) begin
								rank_q[j] <= SW'(rank_q[j] - 1'b1);
							end
						end
						act_q[tgt_q]  <= 1'b0;
						rank_q[tgt_q] <= '0;
					end
				end
				dtq_pkg::ST_LINS: begin
					for (int j = 0; j < TIMERS; j++) begin
						if (act_q[j] && SW'(j) != tgt_q && rank_q[j] >= pos_q) begin
							rank_q[j] <= SW'(rank_q[j] + 1'b1);
						end
					end
					rank_q[tgt_q] <= pos_q;
					act_q[tgt_q]  <= 1'b1;
				end
				dtq_pkg::ST_SCAN: begin
					if (fire) begin
						fmask_q[head_id] <= 1'b1;
						nfired_q         <= 4'(nfired_q + 4'd1);
					end
				end
				dtq_pkg::ST_EMIT: emit_q <= 3'(emit_q + 3'd1);
				default: ;
			endcase
		end
	end

	// payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			dtq_pkg::ST_IDLE: if (q_in.valid) op_q <= q_in.item;
			dtq_pkg::ST_CMD: begin
				tgt_q        <= SW'(int'(op_q.cmd.timer_id));
				link_after_q <= (op_q.cmd.kind == dtq_pkg::KIND_SCHED);
				new_d_q      <= sch_d;
				if (op_q.sched_ok) begin
					per_q[SW'(int'(op_q.cmd.timer_id))] <= op_q.cmd.repeat_period;
				end
			end
			dtq_pkg::ST_LPOS: pos_q <= pos_cnt[SW-1:0];
			dtq_pkg::ST_LINS: dl_q[tgt_q] <= new_d_q;
			dtq_pkg::ST_SCAN: begin
				if (fire) begin
					tgt_q        <= head_id;
					link_after_q <= (per_q[head_id] != '0);
					fired_q[nfired_q[2:0]] <= head_id;
				end
			end
			dtq_pkg::ST_ADV: new_d_q <= adv_d1;
			dtq_pkg::ST_DIV: begin
				if (div_done) begin
					new_d_q <= fin_sum[64] ? dtq_pkg::ALL_ONES : fin_sum[63:0];
				end
			end
			dtq_pkg::ST_HEAD: next_q <= head_found ? dl_q[head_id] : dtq_pkg::ALL_ONES;
			default: ;
		endcase
	end

endmodule

// File: rtl/core/deadline_timer_queue_unit.sv
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit
// Multi-slot one-shot / periodic deadline timer with ordered expiry.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; a two-entry queue
// sits between the command front end and the executing back end, so busy
// only rises once two items wait. Results come out one per cycle on
// result_valid and cannot be stalled; every result of an item carries the
// same next_deadline and the final one has last set. The back end pops an
// item, then runs command, unlink, position, insert and head for an accepted
// schedule; a cancel skips position and insert, and a refused schedule or
// the unused kind goes straight to head. In a tick, a fired one-shot slot is
// unlinked and a fired periodic slot is advanced, unlinked and re-inserted;
// one that missed more than one period also waits on the bit-serial remainder
// unit. A tick fires at most 8 slots. Registers: tick_rate_hz at address 0
// (zero rejects all schedules), handler_present_mask at 4.
// ----------------------------------------------------------------------------
module deadline_timer_queue_unit #(
	parameter int TIMERS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// command channel
	input  logic                           start,
	input  dtq_pkg::cmd_t                  cmd,
	output logic                           busy,
	// result channel
	output logic                           result_valid,
	output dtq_pkg::res_t                  result,
	// config port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [dtq_pkg::PADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);

	logic [31:0]      tick_rate_q;
	logic [7:0]       handler_mask_q;
	dtq_pkg::q_link_t q_link;
	logic             q_pop;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q    <= '0;
			handler_mask_q <= '0;
		end else if (wr_en) begin
			if (paddr == dtq_pkg::ADDR_TICK_RATE) tick_rate_q    <= pwdata;
			if (paddr == dtq_pkg::ADDR_HANDLER)   handler_mask_q <= pwdata[7:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == dtq_pkg::ADDR_TICK_RATE)    prdata = tick_rate_q;
		else if (paddr == dtq_pkg::ADDR_HANDLER) prdata = {24'd0, handler_mask_q};
	end

	// front: accept and classify
	dtq_front #(.TIMERS(TIMERS)) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.cmd          (cmd),
		.busy         (busy),
		.tick_rate    (tick_rate_q),
		.handler_mask (handler_mask_q),
		.q_out        (q_link),
		.q_pop        (q_pop)
	);

	// back: slot table, order, expiry and results
	dtq_back #(.TIMERS(TIMERS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_in         (q_link),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule
